// ===== rtl/dtpm_pkg.sv =====
`default_nettype none
package dtpm_pkg;

    localparam int TICK_WIDTH   = 32;
    localparam int SAMPLE_WIDTH = 10;
    localparam int THR_WIDTH    = 10;
    localparam int HITS_WIDTH   = 8;
    localparam int OUT_WIDTH    = 32;
    localparam int APB_DWIDTH   = 32;
    localparam int APB_AWIDTH   = 3;
    localparam int CMP_WIDTH    = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;

    localparam logic [THR_WIDTH-1:0]  RESET_THRESHOLD = THR_WIDTH'(32'h20);
    localparam logic [HITS_WIDTH-1:0] RESET_HITS      = HITS_WIDTH'(32'd5);

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_HITS      = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_FALL = 3'd0,
        PH_DEB_FALL  = 3'd1,
        PH_MARK_FALL = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_DEB_RISE  = 3'd4,
        PH_MARK_RISE = 3'd5
    } t_phase;

    typedef struct packed {
        logic [THR_WIDTH-1:0]  threshold;
        logic [HITS_WIDTH-1:0] hit_limit;
    } t_cfg;

    typedef struct packed {
        logic                    vld;
        logic                    opcode;
        logic [SAMPLE_WIDTH-1:0] sample;
    } t_in_stage;

    typedef struct packed {
        logic                 vld;
        logic [OUT_WIDTH-1:0] period_ticks;
        logic [OUT_WIDTH-1:0] high_ticks;
        logic [OUT_WIDTH-1:0] low_ticks;
    } t_result;

    function automatic logic [OUT_WIDTH-1:0] to_out(input logic [TICK_WIDTH-1:0] t);
        logic [TICK_WIDTH+OUT_WIDTH-1:0] w;
        w = {{OUT_WIDTH{1'b0}}, t};
        return w[OUT_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dtpm_cfg.sv =====
`default_nettype none
module dtpm_cfg (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [dtpm_pkg::APB_AWIDTH-1:0]     paddr,
    input  wire [dtpm_pkg::APB_DWIDTH-1:0]     pwdata,
    output logic [dtpm_pkg::APB_DWIDTH-1:0]    prdata,
    output logic                               pready,
    output dtpm_pkg::t_cfg                     o_cfg
);

    logic [dtpm_pkg::THR_WIDTH-1:0]  r_threshold;
    logic [dtpm_pkg::HITS_WIDTH-1:0] r_hits;
    logic                            w_wr;
    logic                            w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= dtpm_pkg::RESET_THRESHOLD;
            r_hits      <= dtpm_pkg::RESET_HITS;
        end else if (w_wr) begin
            case (w_idx)
                dtpm_pkg::REG_THRESHOLD: r_threshold <= pwdata[dtpm_pkg::THR_WIDTH-1:0];
                dtpm_pkg::REG_HITS:      r_hits      <= pwdata[dtpm_pkg::HITS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            dtpm_pkg::REG_THRESHOLD:
                prdata = dtpm_pkg::APB_DWIDTH'(r_threshold);
            dtpm_pkg::REG_HITS:
                prdata = dtpm_pkg::APB_DWIDTH'(r_hits);
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.threshold = r_threshold;
    assign o_cfg.hit_limit = r_hits;

endmodule
`default_nettype wire

// ===== rtl/dtpm_core.sv =====
`default_nettype none
module dtpm_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  dtpm_pkg::t_cfg        i_cfg,
    input  dtpm_pkg::t_in_stage   i_item,
    input  wire                   i_adv,
    output dtpm_pkg::t_result     o_res
);

    dtpm_pkg::t_phase r_phase, n_phase;
    logic [dtpm_pkg::HITS_WIDTH-1:0] r_low_run, n_low_run;
    logic [dtpm_pkg::HITS_WIDTH-1:0] r_high_run, n_high_run;
    logic [dtpm_pkg::TICK_WIDTH-1:0] r_tick, n_tick;
    logic [dtpm_pkg::TICK_WIDTH-1:0] r_fall_mark, n_fall_mark;
    logic [dtpm_pkg::TICK_WIDTH-1:0] r_rise_mark, n_rise_mark;
    logic [dtpm_pkg::TICK_WIDTH-1:0] r_high_time, n_high_time;
    logic [dtpm_pkg::HITS_WIDTH-1:0] w_low_inc, w_high_inc;
    logic [dtpm_pkg::TICK_WIDTH-1:0] w_low_time, w_period;
    logic                            w_fire, w_below, w_emit;
    dtpm_pkg::t_result               r_res;

    assign w_fire     = i_item.vld & i_adv;
    assign w_below    = dtpm_pkg::CMP_WIDTH'(i_item.sample)
                      < dtpm_pkg::CMP_WIDTH'(i_cfg.threshold);
    assign w_low_inc  = r_low_run + 1'b1;
    assign w_high_inc = r_high_run + 1'b1;
    assign w_low_time = r_tick - r_fall_mark;
    assign w_period   = r_tick - r_rise_mark;

    always_comb begin
        n_phase     = r_phase;
        n_low_run   = r_low_run;
        n_high_run  = r_high_run;
        n_tick      = r_tick;
        n_fall_mark = r_fall_mark;
        n_rise_mark = r_rise_mark;
        n_high_time = r_high_time;
        w_emit      = 1'b0;
        if (w_fire) begin
            if (i_item.opcode == dtpm_pkg::OP_TICK) begin
                n_tick = r_tick + 1'b1;
            end else begin
                case (r_phase)
                    dtpm_pkg::PH_WAIT_FALL: begin
                        if (w_below) begin
                            n_phase    = dtpm_pkg::PH_DEB_FALL;
                            n_low_run  = dtpm_pkg::HITS_WIDTH'(1);
                            n_high_run = '0;
                        end
                    end
                    dtpm_pkg::PH_DEB_FALL: begin
                        if (w_below) begin
                            n_low_run = w_low_inc;
                            if (w_low_inc >= i_cfg.hit_limit) begin
                                n_phase = dtpm_pkg::PH_MARK_FALL;
                            end
                        end else begin
                            n_low_run = '0;
                        end
                    end
                    dtpm_pkg::PH_MARK_FALL: begin
                        n_fall_mark = r_tick;
                        n_high_time = r_tick - r_rise_mark;
                        n_phase     = dtpm_pkg::PH_WAIT_RISE;
                    end
                    dtpm_pkg::PH_WAIT_RISE: begin
                        if (!w_below) begin
                            n_phase    = dtpm_pkg::PH_DEB_RISE;
                            n_low_run  = '0;
                            n_high_run = dtpm_pkg::HITS_WIDTH'(1);
                        end
                    end
                    dtpm_pkg::PH_DEB_RISE: begin
                        if (!w_below) begin
                            n_high_run = w_high_inc;
                            if (w_high_inc >= i_cfg.hit_limit) begin
                                n_phase = dtpm_pkg::PH_MARK_RISE;
                            end
                        end else begin
                            n_high_run = '0;
                        end
                    end
                    dtpm_pkg::PH_MARK_RISE: begin
                        n_rise_mark = r_tick;
                        n_phase     = dtpm_pkg::PH_WAIT_FALL;
                        w_emit      = 1'b1;
                    end
                    default: begin
                        n_phase = dtpm_pkg::PH_WAIT_FALL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dtpm_pkg::PH_WAIT_FALL;
            r_low_run   <= '0;
            r_high_run  <= '0;
            r_tick      <= '0;
            r_fall_mark <= '0;
            r_rise_mark <= '0;
            r_high_time <= '0;
        end else begin
            r_phase     <= n_phase;
            r_low_run   <= n_low_run;
            r_high_run  <= n_high_run;
            r_tick      <= n_tick;
            r_fall_mark <= n_fall_mark;
            r_rise_mark <= n_rise_mark;
            r_high_time <= n_high_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else if (i_adv) begin
            r_res.vld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_emit) begin
            r_res.period_ticks <= dtpm_pkg::to_out(w_period);
            r_res.high_ticks   <= dtpm_pkg::to_out(r_high_time);
            r_res.low_ticks    <= dtpm_pkg::to_out(w_low_time);
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== rtl/debounced_threshold_period_meter.sv =====
// Debounced threshold period meter.
// Input channel (i_in_valid / o_in_stall): each transaction is either a
// timebase tick (i_opcode 0) or an ADC sample (i_opcode 1, i_sample).
// Samples below the threshold register count as low; a debounced fall and
// a debounced rise each need hit_limit qualifying samples, and each
// mark takes one further sample that latches the tick counter.
// Output channel (o_out_valid / i_out_stall): one transaction per rise mark
// with period, high time and low time in ticks, wrapping modulo 2^32.
// A result is registered: the sample that causes it passes the input
// register, then the result register.
// Throughput: one transaction per cycle while no result is stalled; each
// item passes the phase update logic combinationally between the input and result registers.
// While the receiver stalls a pending result, the input register still
// takes one more transaction, then o_in_stall rises until the result goes.
// Configuration: APB registers threshold (0x0) and hit_limit (0x4).
// Synchronous reset clears the phase, counters, marks and the valid bits of
// both pipeline registers and restores threshold 0x20 and hit_limit 5.
`default_nettype none
module debounced_threshold_period_meter (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_opcode,
    input  wire [dtpm_pkg::SAMPLE_WIDTH-1:0]    i_sample,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [dtpm_pkg::OUT_WIDTH-1:0]      o_period_ticks,
    output logic [dtpm_pkg::OUT_WIDTH-1:0]      o_high_ticks,
    output logic [dtpm_pkg::OUT_WIDTH-1:0]      o_low_ticks,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [dtpm_pkg::APB_AWIDTH-1:0]      paddr,
    input  wire [dtpm_pkg::APB_DWIDTH-1:0]      pwdata,
    output logic [dtpm_pkg::APB_DWIDTH-1:0]     prdata,
    output logic                                pready
);

    dtpm_pkg::t_cfg      w_cfg;
    dtpm_pkg::t_in_stage r_in;
    dtpm_pkg::t_result   w_res;
    logic                w_adv;
    logic                w_acc;

    assign w_adv      = ~w_res.vld | ~i_out_stall;
    assign o_in_stall = r_in.vld & ~w_adv;
    assign w_acc      = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (w_acc) begin
            r_in.vld <= 1'b1;
        end else if (w_adv) begin
            r_in.vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in.opcode <= i_opcode;
            r_in.sample <= i_sample;
        end
    end

    dtpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dtpm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_item  (r_in),
        .i_adv   (w_adv),
        .o_res   (w_res)
    );

    assign o_out_valid    = w_res.vld;
    assign o_period_ticks = w_res.period_ticks;
    assign o_high_ticks   = w_res.high_ticks;
    assign o_low_ticks    = w_res.low_ticks;

endmodule
`default_nettype wire
